>>> src/cad_pkg.sv
// Shared types, constants and calendar tables for the date adder.
package cad_pkg;

	// Default configuration
	localparam int OFFSET_BITS_DEF = 21;
	localparam int YEAR_MAX_DEF    = 9999;

	// Result status codes
	typedef logic [1:0] status_t;
	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_BAD_DATE = 2'd1;
	localparam status_t ST_RANGE    = 2'd2;

	// Days in 400-, 100-, 4- and 1-year spans
	localparam int D400 = 146097;
	localparam int D100 = 36524;
	localparam int D4   = 1461;
	localparam int D1   = 365;

	// Span lengths in years
	localparam int YEARS_400 = 400;
	localparam int YEARS_100 = 100;
	localparam int YEARS_4   = 4;

	// Quotient widths of the century, quad and single-year digits
	localparam int C100_BITS = 2;
	localparam int C4_BITS   = 5;
	localparam int C1_BITS   = 2;

	// Last quad in a century, last year in a quad, last century in a 400-year span
	localparam int LAST_QUAD = 24;
	localparam int LAST_YEAR = 3;
	localparam int LAST_CENT = 3;

	// y / 100 as (y * RECIP_100) >> RECIP_SHIFT, exact for 14-bit y
	localparam int RECIP_100   = 83887;
	localparam int RECIP_SHIFT = 23;

	// Width of the day count of one 400-year span
	localparam int D400_BITS = 18;

	// Day count within a century fits 16 bits; r / 1461 as (r * RECIP_4) >> RECIP_SHIFT_4
	localparam int CENT_REM_BITS = 16;
	localparam int RECIP_SHIFT_4 = 27;
	localparam int RECIP_4_BITS  = 17;
	localparam logic [RECIP_4_BITS-1:0] RECIP_4 =
		RECIP_4_BITS'((64'd1 << RECIP_SHIFT_4) / D4 + 1);

	// Span division steps
	localparam int DIV_STEPS = 6;
	typedef logic [2:0] dstep_t;
	localparam dstep_t DS_Q400 = 3'd0;  // 400-year digit by reciprocal
	localparam dstep_t DS_R400 = 3'd1;  // remainder of the 400-year digit
	localparam dstep_t DS_C100 = 3'd2;  // century digit and remainder
	localparam dstep_t DS_Q4   = 3'd3;  // quad digit by reciprocal
	localparam dstep_t DS_R4   = 3'd4;  // remainder of the quad digit
	localparam dstep_t DS_C1   = 3'd5;  // single-year digit and remainder

	localparam int DAYS_IN_YEAR_MAX = 365;
	localparam logic [3:0] FEB      = 4'd2;
	localparam logic [3:0] DEC      = 4'd12;
	localparam logic [4:0] FEB_LEAP = 5'd29;

	localparam logic [4:0] MONTH_LEN [0:12] = '{
		5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	// Days before the first of each month, common year
	localparam logic [8:0] CUM_DAYS [0:12] = '{
		9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
		9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
	};

	typedef struct packed {
		logic    load;
		logic    ydiv;
		logic    base;
		logic    sum1;
		logic    sum2;
		logic    div_init;
		logic    div_step;
		logic    year;
		logic    month;
		logic    finish;
		status_t code;
	} cmd_t;

	typedef struct packed {
		logic date_ok;
		logic in_range;
	} stat_t;

	// Length of month m; 0 for a month code outside 1..12
	function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		len = 5'd0;
		if (m >= 4'd1 && m <= DEC) len = MONTH_LEN[m];
		if (m == FEB && leap) len = FEB_LEAP;
		return len;
	endfunction

	// Days in the year before the first of month m
	function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
		logic [8:0] cum;
		cum = 9'd0;
		if (m >= 4'd1 && m <= DEC) cum = CUM_DAYS[m];
		if (leap && m > FEB && m <= DEC) cum = cum + 9'd1;
		return cum;
	endfunction

endpackage

>>> src/cad_ctrl.sv
// Sequencer for the date adder: walks the datapath through its steps.
module cad_ctrl #(
	parameter int DIV_STEPS = cad_pkg::DIV_STEPS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  cad_pkg::stat_t               stat,
	output cad_pkg::cmd_t                cmd,
	output logic [$clog2(DIV_STEPS)-1:0] step
);

	localparam int STEP_W = $clog2(DIV_STEPS);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_YDIV   = 4'd1;
	localparam logic [3:0] S_BASE   = 4'd2;
	localparam logic [3:0] S_SUM1   = 4'd3;
	localparam logic [3:0] S_SUM2   = 4'd4;
	localparam logic [3:0] S_CHECK  = 4'd5;
	localparam logic [3:0] S_DIV    = 4'd6;
	localparam logic [3:0] S_YEAR   = 4'd7;
	localparam logic [3:0] S_MONTH  = 4'd8;
	localparam logic [3:0] S_FINISH = 4'd9;

	logic [3:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;

	assign busy = (state_q != S_IDLE);
	assign step = step_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_YDIV;
				end
			end
			S_YDIV: begin
				cmd.ydiv = 1'b1;
				state_d  = S_BASE;
			end
			S_BASE: begin
				cmd.base = 1'b1;
				state_d  = S_SUM1;
			end
			S_SUM1: begin
				if (!stat.date_ok) begin
					cmd.finish = 1'b1;
					cmd.code   = cad_pkg::ST_BAD_DATE;
					state_d    = S_IDLE;
				end else begin
					cmd.sum1 = 1'b1;
					state_d  = S_SUM2;
				end
			end
			S_SUM2: begin
				cmd.sum2 = 1'b1;
				state_d  = S_CHECK;
			end
			S_CHECK: begin
				if (!stat.in_range) begin
					cmd.finish = 1'b1;
					cmd.code   = cad_pkg::ST_RANGE;
					state_d    = S_IDLE;
				end else begin
					cmd.div_init = 1'b1;
					step_d       = '0;
					state_d      = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = S_YEAR;
				end else begin
					step_d = step_q + STEP_W'(1);
				end
			end
			S_YEAR: begin
				cmd.year = 1'b1;
				state_d  = S_MONTH;
			end
			S_MONTH: begin
				cmd.month = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				cmd.code   = cad_pkg::ST_OK;
				state_d    = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

>>> src/cad_dp.sv
// Datapath for the date adder: day count, range check, digit division, month split.
module cad_dp #(
	parameter int OFFSET_BITS = 21,
	parameter int YEAR_MAX    = 9999,
	parameter int Q400_BITS   = 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [4:0]             start_day,
	input  logic [3:0]             start_month,
	input  logic [13:0]            start_year,
	input  logic [OFFSET_BITS-1:0] day_offset,
	input  cad_pkg::cmd_t          cmd,
	input  cad_pkg::dstep_t        step,
	output cad_pkg::stat_t         stat,
	output logic                   done,
	output logic [4:0]             result_day,
	output logic [3:0]             result_month,
	output logic [13:0]            result_year,
	output cad_pkg::status_t       status
);

	localparam int LAST_DAY = YEAR_MAX * 365 + YEAR_MAX / 4 - YEAR_MAX / 100
		+ YEAR_MAX / 400 - 1;
	localparam int DAY_BITS = $clog2(LAST_DAY + 1);
	localparam int N_BITS   = ((DAY_BITS > OFFSET_BITS) ? DAY_BITS : OFFSET_BITS) + 2;
	localparam int YR_BITS  = $clog2(YEAR_MAX + 1);
	localparam int YS_BITS  = YR_BITS + 9;

	// n / 146097 as (n * RECIP_400) >> S400, exact for any day count
	localparam int S400   = DAY_BITS + cad_pkg::D400_BITS;
	localparam int R400_W = DAY_BITS + 2;
	localparam int P400_W = DAY_BITS + R400_W;
	localparam logic [R400_W-1:0] RECIP_400 =
		R400_W'((64'd1 << S400) / cad_pkg::D400 + 1);
	localparam int P4_W   = cad_pkg::CENT_REM_BITS + cad_pkg::RECIP_4_BITS;

	// Input item
	logic [4:0]             day_q;
	logic [3:0]             mon_in_q;
	logic [13:0]            year_in_q;
	logic [OFFSET_BITS-1:0] off_q;

	// Day count
	logic [7:0]        ydiv_q;
	logic [7:0]        pcent_q;
	logic              leap_q;
	logic              valid_q;
	logic [N_BITS-1:0] base_q;
	logic [N_BITS-1:0] acc_q;
	logic [8:0]        doy_q;
	logic [N_BITS-1:0] n_q;

	// Division and split
	logic [DAY_BITS-1:0]           rem_q;
	logic [Q400_BITS-1:0]          q400_q;
	logic [cad_pkg::C100_BITS-1:0] c100_q;
	logic [cad_pkg::C4_BITS-1:0]   c4_q;
	logic [cad_pkg::C1_BITS-1:0]   c1_q;
	logic [YR_BITS-1:0]            ryear_q;
	logic                          rleap_q;
	logic [3:0]                    rmon_q;

	// Result registers
	logic               done_q;
	logic [4:0]         res_day_q;
	logic [3:0]         res_mon_q;
	logic [13:0]        res_year_q;
	cad_pkg::status_t   status_q;

	// y / 100 by reciprocal
	logic [30:0] yk;
	assign yk = 31'(year_in_q) * 31'(cad_pkg::RECIP_100);

	// Century flags, leap year, start date check
	logic        ycent;
	logic [7:0]  pcent;
	logic        leap;
	logic [13:0] ym1;
	logic [4:0]  mlen;
	logic        date_ok;
	assign ycent   = (14'(ydiv_q) * 14'(cad_pkg::YEARS_100)) == year_in_q;
	assign pcent   = ycent ? (ydiv_q - 8'd1) : ydiv_q;
	assign leap    = ycent ? (ydiv_q[1:0] == 2'b00) : (year_in_q[1:0] == 2'b00);
	assign ym1     = year_in_q - 14'd1;
	assign mlen    = cad_pkg::month_days(mon_in_q, leap);
	assign date_ok = (mon_in_q >= 4'd1) && (mon_in_q <= cad_pkg::DEC)
		&& (year_in_q != 14'd0) && (32'(year_in_q) <= YEAR_MAX)
		&& (day_q != 5'd0) && (day_q <= mlen);

	// Start date check and range check of the day count
	assign stat.date_ok  = valid_q;
	assign stat.in_range = !n_q[N_BITS-1] && (n_q <= N_BITS'(LAST_DAY));

	// 400-year digit: reciprocal multiply of the day count
	logic [P400_W-1:0]    p400;
	logic [Q400_BITS-1:0] q400_d;
	assign p400   = P400_W'(rem_q) * P400_W'(RECIP_400);
	assign q400_d = p400[S400 +: Q400_BITS];

	// Century digit: compare against 1, 2 and 3 centuries, capped at 3
	logic [cad_pkg::C100_BITS-1:0] c100_d;
	assign c100_d = (rem_q >= DAY_BITS'(3 * cad_pkg::D100)) ? cad_pkg::C100_BITS'(3)
		: (rem_q >= DAY_BITS'(2 * cad_pkg::D100)) ? cad_pkg::C100_BITS'(2)
		: (rem_q >= DAY_BITS'(cad_pkg::D100)) ? cad_pkg::C100_BITS'(1)
		: cad_pkg::C100_BITS'(0);

	// Quad digit: reciprocal multiply of the day within the century
	logic [cad_pkg::CENT_REM_BITS-1:0] rcent;
	logic [P4_W-1:0]                   p4;
	logic [cad_pkg::C4_BITS-1:0]       c4_d;
	assign rcent = rem_q[cad_pkg::CENT_REM_BITS-1:0];
	assign p4    = P4_W'(rcent) * P4_W'(cad_pkg::RECIP_4);
	assign c4_d  = p4[cad_pkg::RECIP_SHIFT_4 +: cad_pkg::C4_BITS];

	// Single-year digit: compare against 1, 2 and 3 years, capped at 3
	logic [cad_pkg::C1_BITS-1:0] c1_d;
	assign c1_d = (rem_q >= DAY_BITS'(3 * cad_pkg::D1)) ? cad_pkg::C1_BITS'(3)
		: (rem_q >= DAY_BITS'(2 * cad_pkg::D1)) ? cad_pkg::C1_BITS'(2)
		: (rem_q >= DAY_BITS'(cad_pkg::D1)) ? cad_pkg::C1_BITS'(1)
		: cad_pkg::C1_BITS'(0);

	// Year from digits
	logic [YS_BITS-1:0] ysum;
	logic               rleap;
	assign ysum = YS_BITS'(q400_q) * YS_BITS'(cad_pkg::YEARS_400)
		+ YS_BITS'(c100_q) * YS_BITS'(cad_pkg::YEARS_100)
		+ YS_BITS'(c4_q) * YS_BITS'(cad_pkg::YEARS_4)
		+ YS_BITS'(c1_q) + YS_BITS'(1);
	assign rleap = (c1_q == cad_pkg::C1_BITS'(cad_pkg::LAST_YEAR))
		&& ((c4_q != cad_pkg::C4_BITS'(cad_pkg::LAST_QUAD))
		|| (c100_q == cad_pkg::C100_BITS'(cad_pkg::LAST_CENT)));

	// Month: count month starts at or below the day of year
	logic [8:0] r_doy;
	logic [3:0] mcount;
	assign r_doy = rem_q[8:0];
	always_comb begin
		mcount = 4'd1;
		for (int k = 2; k <= 12; k++) begin
			if (r_doy >= cad_pkg::days_before_month(4'(k), rleap_q)) mcount = mcount + 4'd1;
		end
	end

	// Day of month
	logic [8:0] rday;
	assign rday = r_doy - cad_pkg::days_before_month(rmon_q, rleap_q) + 9'd1;

	// Datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q     <= start_day;
			mon_in_q  <= start_month;
			year_in_q <= start_year;
			off_q     <= day_offset;
		end
		if (cmd.ydiv) begin
			ydiv_q <= yk[30:cad_pkg::RECIP_SHIFT];
		end
		if (cmd.base) begin
			pcent_q <= pcent;
			leap_q  <= leap;
			valid_q <= date_ok;
			base_q  <= N_BITS'(ym1) * N_BITS'(cad_pkg::D1) + N_BITS'(ym1 >> 2);
		end
		if (cmd.sum1) begin
			acc_q <= base_q - N_BITS'(pcent_q) + N_BITS'(pcent_q >> 2);
			doy_q <= cad_pkg::days_before_month(mon_in_q, leap_q) + 9'(day_q) - 9'd1;
		end
		if (cmd.sum2) begin
			n_q <= acc_q + N_BITS'(doy_q)
				+ {{(N_BITS-OFFSET_BITS){off_q[OFFSET_BITS-1]}}, off_q};
		end
		if (cmd.div_init) begin
			rem_q <= n_q[DAY_BITS-1:0];
		end
		// Span digits and remainders over the division steps, remainder kept in rem_q
		if (cmd.div_step) begin
			unique case (step)
				cad_pkg::DS_Q400: begin
					q400_q <= q400_d;
				end
				cad_pkg::DS_R400: begin
					rem_q <= rem_q - DAY_BITS'(q400_q) * DAY_BITS'(cad_pkg::D400);
				end
				cad_pkg::DS_C100: begin
					c100_q <= c100_d;
					rem_q  <= rem_q - DAY_BITS'(c100_d) * DAY_BITS'(cad_pkg::D100);
				end
				cad_pkg::DS_Q4: begin
					c4_q <= c4_d;
				end
				cad_pkg::DS_R4: begin
					rem_q <= rem_q - DAY_BITS'(c4_q) * DAY_BITS'(cad_pkg::D4);
				end
				cad_pkg::DS_C1: begin
					c1_q  <= c1_d;
					rem_q <= rem_q - DAY_BITS'(c1_d) * DAY_BITS'(cad_pkg::D1);
				end
				default: begin
				end
			endcase
		end
		if (cmd.year) begin
			ryear_q <= ysum[YR_BITS-1:0];
			rleap_q <= rleap;
		end
		if (cmd.month) begin
			rmon_q <= mcount;
		end
		if (cmd.finish) begin
			status_q <= cmd.code;
			if (cmd.code == cad_pkg::ST_OK) begin
				res_day_q  <= rday[4:0];
				res_mon_q  <= rmon_q;
				res_year_q <= 14'(ryear_q);
			end else begin
				res_day_q  <= '0;
				res_mon_q  <= '0;
				res_year_q <= '0;
			end
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done         = done_q;
	assign result_day   = res_day_q;
	assign result_month = res_mon_q;
	assign result_year  = res_year_q;
	assign status       = status_q;

endmodule

>>> src/calendar_add_days_core.sv
// Top level of the Gregorian date adder: date plus signed day count.
//
// A transfer is taken when start is high and busy is low. The result appears
// on result_day, result_month, result_year and status for exactly one cycle
// with done high, and the receiver must take it then; busy is already low in
// that cycle, so the next start may coincide with done. An invalid start date
// finishes after the start date check, a result out of range after the range
// check, and any other item after the span division and month split; busy
// stays high until then, so no new item is taken before the last one is
// through. The long path is the split of the day count into 400-,
// 100-, 4- and 1-year spans: reciprocal multiplies for the 400-year and quad
// digits, compare-subtract for the century and single-year digits.
// Status 0 is a good result, 1 an invalid start date, 2 a result outside
// years 1..YEAR_MAX; on status 1 or 2 the date outputs are zero.
module calendar_add_days_core #(
	parameter int OFFSET_BITS = cad_pkg::OFFSET_BITS_DEF,
	parameter int YEAR_MAX    = cad_pkg::YEAR_MAX_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [4:0]             start_day,
	input  logic [3:0]             start_month,
	input  logic [13:0]            start_year,
	input  logic [OFFSET_BITS-1:0] day_offset,
	output logic                   done,
	output logic [4:0]             result_day,
	output logic [3:0]             result_month,
	output logic [13:0]            result_year,
	output logic [1:0]             status
);

	localparam int Q400_BITS = (YEAR_MAX / 400 > 0) ? $clog2(YEAR_MAX / 400 + 1) : 1;
	localparam int DIV_STEPS = cad_pkg::DIV_STEPS;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	cad_pkg::cmd_t     cmd;
	cad_pkg::stat_t    stat;
	logic [STEP_W-1:0] step;

	// Sequencer
	cad_ctrl #(
		.DIV_STEPS (DIV_STEPS)
	) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.stat   (stat),
		.cmd    (cmd),
		.step   (step)
	);

	// Datapath
	cad_dp #(
		.OFFSET_BITS (OFFSET_BITS),
		.YEAR_MAX    (YEAR_MAX),
		.Q400_BITS   (Q400_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.start_day    (start_day),
		.start_month  (start_month),
		.start_year   (start_year),
		.day_offset   (day_offset),
		.cmd          (cmd),
		.step         (step),
		.stat         (stat),
		.done         (done),
		.result_day   (result_day),
		.result_month (result_month),
		.result_year  (result_year),
		.status       (status)
	);

endmodule
